[design/spm_pkg.sv]
// Shared types and constants for the sensor plausibility monitor.
// No dependencies; the core, spm_cfg_regs, spm_eval and the bench import this package.
`default_nettype none

package spm_pkg;

    // Item codes carried in the opcode field
    typedef enum logic [3:0] {
        OP_TICK   = 4'd0,
        OP_AX     = 4'd1,
        OP_AY     = 4'd2,
        OP_YAW    = 4'd3,
        OP_STEER  = 4'd4,
        OP_WHEEL0 = 4'd5,
        OP_WHEEL1 = 4'd6,
        OP_WHEEL2 = 4'd7,
        OP_WHEEL3 = 4'd8,
        OP_INV    = 4'd9,
        OP_CONE0  = 4'd10,
        OP_CONE1  = 4'd11,
        OP_STATUS = 4'd12,
        OP_TARGET = 4'd13
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHECKS_EN   = 3'd0,
        CFG_SENSOR_TMO  = 3'd1,
        CFG_MAP_TMO     = 3'd2,
        CFG_MAX_LONG    = 3'd3,
        CFG_MAX_LAT     = 3'd4,
        CFG_MAX_YAW     = 3'd5,
        CFG_MAX_SPEED   = 3'd6,
        CFG_ERROR_LIMIT = 3'd7
    } cfg_idx_t;

    localparam int CFG_DATA_W = 22;
    localparam int SLOTS      = 9;

    localparam logic signed [15:0] STEER_LIMIT_Q = 16'sd5376;  // 21.0 in Q8.8
    localparam logic signed [15:0] HALF_MPS_Q    = 16'sd128;   // 0.5 in Q8.8
    localparam logic [2:0]         ST_DRIVING    = 3'd3;
    localparam logic [2:0]         ST_FINISHED   = 3'd5;
    localparam logic [6:0]         BRAKE_FULL    = 7'd100;
    localparam logic [6:0]         BRAKE_NONE    = 7'd0;

    typedef struct packed {
        logic        checks_en;
        logic [19:0] sensor_timeout_us;
        logic [21:0] map_timeout_us;
        logic [14:0] max_long_accel;
        logic [14:0] max_lat_accel;
        logic [14:0] max_yaw_rate;
        logic [14:0] max_speed;
        logic [7:0]  error_limit;
    } cfg_t;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [15:0] sample;
        logic [31:0]        time_us;
        logic               actuator_ok;
    } item_t;

    typedef struct packed {
        logic               run_ok;
        logic               steer_ok;
        logic [2:0]         drive_status;
        logic [6:0]         brake_request;
        logic [7:0]         error_level;
        logic signed [15:0] speed;
    } res_t;

endpackage

`default_nettype wire

[design/spm_if.sv]
// Valid/ready channel interfaces for sample words and result words.
// No dependencies.
`default_nettype none

interface spm_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic signed [15:0] sample;
    logic [31:0]        time_us;
    logic               actuator_ok;

    modport source (output valid, output opcode, output sample, output time_us,
                    output actuator_ok, input ready);
    modport sink   (input valid, input opcode, input sample, input time_us,
                    input actuator_ok, output ready);
endinterface

interface spm_out_if;
    logic               valid;
    logic               ready;
    logic               run_ok;
    logic               steer_ok;
    logic [2:0]         drive_status;
    logic [6:0]         brake_request;
    logic [7:0]         error_level;
    logic signed [15:0] speed;

    modport source (output valid, output run_ok, output steer_ok, output drive_status,
                    output brake_request, output error_level, output speed, input ready);
    modport sink   (input valid, input run_ok, input steer_ok, input drive_status,
                    input brake_request, input error_level, input speed, output ready);
endinterface

`default_nettype wire

[design/sensor_plausibility_monitor_core.sv]
// Top level of the sensor plausibility monitor: input stage, evaluation and
// result register. Depends on spm_pkg, spm_if, spm_cfg_regs and spm_eval.
//
//   channel     dir  word                                               handshake
//   sample_ch   in   opcode, sample, time_us, actuator_ok               valid/ready
//   result_ch   out  run_ok, steer_ok, drive_status, brake_request,     valid/ready
//                    error_level, speed
//   cfg_*       in   cfg_index, cfg_wdata                                cfg_we only
//
// Flow: a word is taken into the input stage, evaluated there against the state
// and, for a tick, its result lands in the result register as it leaves the stage.
// One word per cycle is sustained while no tick waits on a held result; a tick's
// result word is held in the result register until it is taken.
// Reset clears configuration to its defaults, arrival times, error level,
// status and speed at once; no clearing pass.
// Stalls: only a tick waits on the result register; sensor words keep moving
// while a result is held, until a tick reaches the stage and holds the input.
`default_nettype none

module sensor_plausibility_monitor_core #(
    parameter int IMU_WEIGHT      = 1,
    parameter int STEER_WEIGHT    = 1,
    parameter int WHEEL_WEIGHT    = 1,
    parameter int INVERTER_WEIGHT = 1,
    parameter int MAP_WEIGHT      = 1,
    parameter int ERROR_MAX       = 255
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [spm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    spm_in_if.sink                              sample_ch,
    spm_out_if.source                           result_ch
);
    import spm_pkg::*;

    cfg_t  cfg;
    res_t  res;

    // Input stage
    logic  stage_valid_reg, stage_valid_next;
    item_t stage_item_reg;
    item_t in_item;

    // Result register
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;

    logic  stage_is_tick;
    logic  out_free;
    logic  stage_fire;
    logic  take_in;

    spm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    spm_eval #(
        .IMU_WEIGHT      (IMU_WEIGHT),
        .STEER_WEIGHT    (STEER_WEIGHT),
        .WHEEL_WEIGHT    (WHEEL_WEIGHT),
        .INVERTER_WEIGHT (INVERTER_WEIGHT),
        .MAP_WEIGHT      (MAP_WEIGHT),
        .ERROR_MAX       (ERROR_MAX)
    ) u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (stage_fire),
        .item  (stage_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign in_item.opcode      = sample_ch.opcode;
    assign in_item.sample      = sample_ch.sample;
    assign in_item.time_us     = sample_ch.time_us;
    assign in_item.actuator_ok = sample_ch.actuator_ok;

    // A staged tick needs room in the result register; other words never wait
    assign stage_is_tick   = stage_item_reg.opcode == OP_TICK;
    assign out_free        = !out_valid_reg || result_ch.ready;
    assign stage_fire      = stage_valid_reg && (!stage_is_tick || out_free);
    assign sample_ch.ready = !stage_valid_reg || stage_fire;
    assign take_in         = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take_in)
            stage_valid_next = 1'b1;
        else if (stage_fire)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (stage_fire && stage_is_tick)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
            stage_item_reg <= in_item;
        if (stage_fire && stage_is_tick)
            out_res_reg <= res;
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.run_ok        = out_res_reg.run_ok;
    assign result_ch.steer_ok      = out_res_reg.steer_ok;
    assign result_ch.drive_status  = out_res_reg.drive_status;
    assign result_ch.brake_request = out_res_reg.brake_request;
    assign result_ch.error_level   = out_res_reg.error_level;
    assign result_ch.speed         = out_res_reg.speed;

`ifndef SYNTHESIS
    // A result only appears after a tick left the input stage
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_fire && stage_is_tick))
        else $error("result word without a tick");

    // A tick that leaves the stage is always delivered
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && stage_is_tick) |=> out_valid_reg)
        else $error("tick lost");

    // A tick blocked by a held result stays in the stage untouched
    a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_is_tick && !out_free)
        |=> (stage_valid_reg && $stable(stage_item_reg)))
        else $error("blocked tick dropped or overwritten");

    // Brake request follows the reported status
    a_brake_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_res_reg.drive_status == ST_DRIVING)
                           == (out_res_reg.brake_request == BRAKE_NONE)))
        else $error("brake request inconsistent with status");
`endif

endmodule

`default_nettype wire

[design/spm_cfg_regs.sv]
// Configuration register bank, written through a plain write port.
// Depends on spm_pkg.
`default_nettype none

module spm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [spm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output spm_pkg::cfg_t                         cfg
);
    import spm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CHECKS_EN:   cfg_next.checks_en         = cfg_wdata[0];
                CFG_SENSOR_TMO:  cfg_next.sensor_timeout_us = cfg_wdata[19:0];
                CFG_MAP_TMO:     cfg_next.map_timeout_us    = cfg_wdata[21:0];
                CFG_MAX_LONG:    cfg_next.max_long_accel    = cfg_wdata[14:0];
                CFG_MAX_LAT:     cfg_next.max_lat_accel     = cfg_wdata[14:0];
                CFG_MAX_YAW:     cfg_next.max_yaw_rate      = cfg_wdata[14:0];
                CFG_MAX_SPEED:   cfg_next.max_speed         = cfg_wdata[14:0];
                CFG_ERROR_LIMIT: cfg_next.error_limit       = cfg_wdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.checks_en         <= 1'b1;
            cfg_reg.sensor_timeout_us <= 20'd50000;
            cfg_reg.map_timeout_us    <= 22'd250000;
            cfg_reg.max_long_accel    <= 15'd3840;
            cfg_reg.max_lat_accel     <= 15'd1280;
            cfg_reg.max_yaw_rate      <= 15'd768;
            cfg_reg.max_speed         <= 15'd19200;
            cfg_reg.error_limit       <= 8'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/spm_eval.sv]
// Per-word evaluation: arrival times, error level, status and speed state,
// and the result of a tick. Depends on spm_pkg.
`default_nettype none

module spm_eval #(
    parameter int IMU_WEIGHT      = 1,
    parameter int STEER_WEIGHT    = 1,
    parameter int WHEEL_WEIGHT    = 1,
    parameter int INVERTER_WEIGHT = 1,
    parameter int MAP_WEIGHT      = 1,
    parameter int ERROR_MAX       = 255
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  spm_pkg::item_t      item,
    input  spm_pkg::cfg_t       cfg,
    output spm_pkg::res_t       res
);
    import spm_pkg::*;

    localparam logic [3:0] W_IMU   = 4'(IMU_WEIGHT);
    localparam logic [3:0] W_STEER = 4'(STEER_WEIGHT);
    localparam logic [3:0] W_WHEEL = 4'(WHEEL_WEIGHT);
    localparam logic [3:0] W_INV   = 4'(INVERTER_WEIGHT);
    localparam logic [3:0] W_MAP   = 4'(MAP_WEIGHT);
    localparam logic [7:0] ERR_CAP = (ERROR_MAX > 255) ? 8'd255 : 8'(ERROR_MAX);

    logic [31:0]        last_arrival_reg [SLOTS];
    logic [7:0]         error_accum_reg,    error_accum_next;
    logic [2:0]         status_held_reg,    status_held_next;
    logic               target_zero_reg,    target_zero_next;
    logic signed [15:0] inverter_speed_reg, inverter_speed_next;

    logic               timed;
    logic [3:0]         slot;
    logic [21:0]        limit;
    logic [3:0]         weight;
    logic               range_bad;
    logic [31:0]        gap;
    logic               late;
    logic [9:0]         err_sum;
    logic [7:0]         err_checked;
    logic signed [16:0] v_ext;
    logic signed [16:0] lim_ext;
    logic signed [15:0] spd_lim;
    logic [2:0]         status_tick;
    logic [7:0]         err_dec;
    logic               run;

    // Source decode: timed slot, gap limit, weight and range verdict
    always_comb
    begin
        timed     = 1'b0;
        slot      = 4'd0;
        limit     = {2'b00, cfg.sensor_timeout_us};
        weight    = 4'd0;
        range_bad = 1'b0;
        v_ext     = {item.sample[15], item.sample};
        lim_ext   = 17'sd0;
        spd_lim   = signed'({1'b0, cfg.max_speed});
        case (op_t'(item.opcode))
            OP_AX:
            begin
                timed     = 1'b1;
                slot      = 4'd0;
                weight    = W_IMU;
                lim_ext   = signed'({2'b00, cfg.max_long_accel});
                range_bad = (v_ext > lim_ext) || (v_ext < -lim_ext);
            end
            OP_AY:
            begin
                weight    = W_IMU;
                lim_ext   = signed'({2'b00, cfg.max_lat_accel});
                range_bad = (v_ext > lim_ext) || (v_ext < -lim_ext);
            end
            OP_YAW:
            begin
                weight    = W_IMU;
                lim_ext   = signed'({2'b00, cfg.max_yaw_rate});
                range_bad = (v_ext > lim_ext) || (v_ext < -lim_ext);
            end
            OP_STEER:
            begin
                timed     = 1'b1;
                slot      = 4'd1;
                weight    = W_STEER;
                range_bad = (item.sample > STEER_LIMIT_Q) || (item.sample < -STEER_LIMIT_Q);
            end
            OP_WHEEL0, OP_WHEEL1, OP_WHEEL2, OP_WHEEL3:
            begin
                timed     = 1'b1;
                slot      = item.opcode - 4'd3;
                weight    = W_WHEEL;
                range_bad = item.sample > spd_lim;
            end
            OP_INV:
            begin
                timed     = 1'b1;
                slot      = 4'd6;
                weight    = W_INV;
                range_bad = (item.sample > spd_lim) || (item.sample < -HALF_MPS_Q);
            end
            OP_CONE0, OP_CONE1:
            begin
                timed     = 1'b1;
                slot      = item.opcode - 4'd3;
                limit     = cfg.map_timeout_us;
                weight    = W_MAP;
                range_bad = item.sample <= 16'sd0;
            end
            default:
            begin
                timed = 1'b0;
            end
        endcase
    end

    // Late and out-of-range add the weight independently, then saturate
    always_comb
    begin
        gap     = item.time_us - last_arrival_reg[slot];
        late    = cfg.checks_en && timed && (gap > {10'd0, limit});
        err_sum = {2'b00, error_accum_reg}
                + (late ? {6'd0, weight} : 10'd0)
                + ((cfg.checks_en && range_bad) ? {6'd0, weight} : 10'd0);
        err_checked = (err_sum > {2'b00, ERR_CAP}) ? ERR_CAP : err_sum[7:0];
    end

    // Tick view: status change, decrement, permissions
    always_comb
    begin
        status_tick = status_held_reg;
        if ((status_held_reg == ST_DRIVING) && target_zero_reg
            && (inverter_speed_reg < HALF_MPS_Q))
            status_tick = ST_FINISHED;
        err_dec = error_accum_reg - {7'd0, (error_accum_reg != 8'd0)};
        if (cfg.checks_en)
            run = (status_tick == ST_DRIVING) && (err_dec < cfg.error_limit)
                  && item.actuator_ok;
        else
            run = status_tick == ST_DRIVING;
        res.run_ok        = run;
        res.steer_ok      = run && (inverter_speed_reg >= HALF_MPS_Q);
        res.drive_status  = status_tick;
        res.brake_request = (status_tick == ST_DRIVING) ? BRAKE_NONE : BRAKE_FULL;
        res.error_level   = err_dec;
        res.speed         = inverter_speed_reg;
    end

    always_comb
    begin
        error_accum_next    = error_accum_reg;
        status_held_next    = status_held_reg;
        target_zero_next    = target_zero_reg;
        inverter_speed_next = inverter_speed_reg;
        case (op_t'(item.opcode))
            OP_TICK:
            begin
                status_held_next = status_tick;
                error_accum_next = err_dec;
            end
            OP_STATUS:
            begin
                if (item.sample < 16'sd0)
                    status_held_next = 3'd0;
                else if (item.sample > 16'sd7)
                    status_held_next = 3'd7;
                else
                    status_held_next = item.sample[2:0];
            end
            OP_TARGET:
            begin
                target_zero_next = item.sample == 16'sd0;
            end
            OP_INV:
            begin
                inverter_speed_next = item.sample;
                error_accum_next    = err_checked;
            end
            default:
            begin
                error_accum_next = err_checked;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                last_arrival_reg[i] <= 32'd0;
            error_accum_reg    <= 8'd0;
            status_held_reg    <= 3'd0;
            target_zero_reg    <= 1'b1;
            inverter_speed_reg <= 16'sd0;
        end
        else if (fire)
        begin
            if (timed)
                last_arrival_reg[slot] <= item.time_us;
            error_accum_reg    <= error_accum_next;
            status_held_reg    <= status_held_next;
            target_zero_reg    <= target_zero_next;
            inverter_speed_reg <= inverter_speed_next;
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for sensor_plausibility_monitor_core: random and directed sample words,
// a cycle-level plausibility tracker predicting each tick's status word.
// Depends on spm_pkg, spm_if and the core itself.

module tb_top;
    import spm_pkg::*;

    // Parameters handed to the core, mirrored by the tracker below
    localparam int IMU_W     = 1;
    localparam int STEER_W   = 1;
    localparam int WHEEL_W   = 1;
    localparam int INV_W     = 1;
    localparam int MAP_W     = 1;
    localparam int ERR_MAX_P = 255;
    localparam int ERR_CAP   = ERR_MAX_P > 255 ? 255 : ERR_MAX_P;

    // Arrival slots of the timed sources
    localparam int SLOT_IMU    = 0;
    localparam int SLOT_STEER  = 1;
    localparam int SLOT_WHEEL0 = 2;
    localparam int SLOT_INV    = 6;
    localparam int SLOT_CONE0  = 7;

    // Codes the core must ignore
    localparam logic [3:0] OP_SPARE_LO = 4'd14;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    localparam int DRAIN_CYCLES = 6;        // lets the pipeline run dry after the last tick result
    localparam int DRAIN_LIMIT  = 2000;
    localparam int WATCHDOG_NS  = 5_000_000;

    localparam cfg_t CFG_RESET = '{
        checks_en:         1'b1,
        sensor_timeout_us: 20'd50000,
        map_timeout_us:    22'd250000,
        max_long_accel:    15'd3840,
        max_lat_accel:     15'd1280,
        max_yaw_rate:      15'd768,
        max_speed:         15'd19200,
        error_limit:       8'd5
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_index = 3'd0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic  in_valid  = 1'b0;
    item_t in_word   = '0;
    logic  out_ready = 1'b0;

    spm_in_if  sample_ch ();
    spm_out_if result_ch ();

    assign sample_ch.valid       = in_valid;
    assign sample_ch.opcode      = in_word.opcode;
    assign sample_ch.sample      = in_word.sample;
    assign sample_ch.time_us     = in_word.time_us;
    assign sample_ch.actuator_ok = in_word.actuator_ok;
    assign result_ch.ready       = out_ready;

    sensor_plausibility_monitor_core #(
        .IMU_WEIGHT      (IMU_W),
        .STEER_WEIGHT    (STEER_W),
        .WHEEL_WEIGHT    (WHEEL_W),
        .INVERTER_WEIGHT (INV_W),
        .MAP_WEIGHT      (MAP_W),
        .ERROR_MAX       (ERR_MAX_P)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Tracker state: shadow registers and plausibility state
    // ------------------------------------------------------------------
    cfg_t                cfg_mdl = CFG_RESET;
    logic [31:0]         arrival_us [SLOTS];
    logic [7:0]          err_lvl;
    logic [2:0]          status_mdl;
    logic                target_is_zero;
    logic signed [15:0]  speed_mdl;

    item_t sample_backlog [$];   // words waiting for the driver
    res_t  status_due [$];       // predicted tick results, oldest first

    logic [31:0] now_us = '0;    // running microsecond clock of the generator
    int          mismatches    = 0;
    int          words_in      = 0;
    int          results_seen  = 0;
    int          settings_used = 1;
    int          err_peak      = 0;
    int          finishes      = 0;
    int          burst_left    = 1;
    int          gap_left      = 0;
    logic [31:0] stall_tick    = '0;

    task automatic report_mismatch(string note);
        $display("[%0t] MISMATCH: %s", $time, note);
        mismatches++;
    endtask

    function automatic void raise_error(int wgt);
        int sum;
        sum = int'(err_lvl) + wgt;
        err_lvl = 8'(sum > ERR_CAP ? ERR_CAP : sum);
        if (int'(err_lvl) > err_peak)
            err_peak = int'(err_lvl);
    endfunction

    // Gap is taken modulo 2^32; the timestamp is kept even with the checks off
    function automatic void note_arrival(int slot, logic [31:0] stamp, logic [31:0] limit,
                                         int wgt);
        logic [31:0] gap;
        gap = stamp - arrival_us[slot];
        arrival_us[slot] = stamp;
        if (cfg_mdl.checks_en && gap > limit)
            raise_error(wgt);
    endfunction

    function automatic void flag_range(bit out_of_range, int wgt);
        if (cfg_mdl.checks_en && out_of_range)
            raise_error(wgt);
    endfunction

    // Advances the plausibility state by one accepted word; a tick queues its status word
    function automatic void track_plausibility(item_t w);
        int          v;
        logic [31:0] sens_tmo;
        logic [31:0] map_tmo;
        res_t        r;
        v        = int'($signed(w.sample));
        sens_tmo = 32'(cfg_mdl.sensor_timeout_us);
        map_tmo  = 32'(cfg_mdl.map_timeout_us);
        r        = '0;
        case (w.opcode)
            OP_TICK: begin
                // finish check comes before the decrement
                if (status_mdl == ST_DRIVING && target_is_zero && speed_mdl < HALF_MPS_Q) begin
                    status_mdl = ST_FINISHED;
                    finishes++;
                end
                if (err_lvl > 8'd0)
                    err_lvl = err_lvl - 8'd1;
                if (cfg_mdl.checks_en)
                    r.run_ok = status_mdl == ST_DRIVING && err_lvl < cfg_mdl.error_limit
                               && w.actuator_ok;
                else
                    r.run_ok = status_mdl == ST_DRIVING;
                r.steer_ok      = r.run_ok && speed_mdl >= HALF_MPS_Q;
                r.drive_status  = status_mdl;
                r.brake_request = status_mdl == ST_DRIVING ? BRAKE_NONE : BRAKE_FULL;
                r.error_level   = err_lvl;
                r.speed         = speed_mdl;
                status_due.push_back(r);
            end
            OP_AX: begin
                note_arrival(SLOT_IMU, w.time_us, sens_tmo, IMU_W);
                flag_range(v < -int'(cfg_mdl.max_long_accel) || v > int'(cfg_mdl.max_long_accel),
                           IMU_W);
            end
            OP_AY:
                flag_range(v < -int'(cfg_mdl.max_lat_accel) || v > int'(cfg_mdl.max_lat_accel),
                           IMU_W);
            OP_YAW:
                flag_range(v < -int'(cfg_mdl.max_yaw_rate) || v > int'(cfg_mdl.max_yaw_rate),
                           IMU_W);
            OP_STEER: begin
                note_arrival(SLOT_STEER, w.time_us, sens_tmo, STEER_W);
                flag_range(v < -int'(STEER_LIMIT_Q) || v > int'(STEER_LIMIT_Q), STEER_W);
            end
            OP_WHEEL0, OP_WHEEL1, OP_WHEEL2, OP_WHEEL3: begin
                note_arrival(SLOT_WHEEL0 + int'(w.opcode - OP_WHEEL0), w.time_us, sens_tmo,
                             WHEEL_W);
                flag_range(v > int'(cfg_mdl.max_speed), WHEEL_W);
            end
            OP_INV: begin
                // range check is on the new sample
                note_arrival(SLOT_INV, w.time_us, sens_tmo, INV_W);
                speed_mdl = w.sample;
                flag_range(v > int'(cfg_mdl.max_speed) || v < -int'(HALF_MPS_Q), INV_W);
            end
            OP_CONE0, OP_CONE1: begin
                note_arrival(SLOT_CONE0 + int'(w.opcode - OP_CONE0), w.time_us, map_tmo, MAP_W);
                flag_range(v <= 0, MAP_W);
            end
            OP_STATUS:
                status_mdl = 3'(v < 0 ? 0 : (v > 7 ? 7 : v));
            OP_TARGET:
                target_is_zero = v == 0;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Shadow registers follow the write port edge by edge
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_mdl <= CFG_RESET;
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHECKS_EN:   cfg_mdl.checks_en         <= cfg_wdata[0];
                CFG_SENSOR_TMO:  cfg_mdl.sensor_timeout_us <= cfg_wdata[19:0];
                CFG_MAP_TMO:     cfg_mdl.map_timeout_us    <= cfg_wdata[21:0];
                CFG_MAX_LONG:    cfg_mdl.max_long_accel    <= cfg_wdata[14:0];
                CFG_MAX_LAT:     cfg_mdl.max_lat_accel     <= cfg_wdata[14:0];
                CFG_MAX_YAW:     cfg_mdl.max_yaw_rate      <= cfg_wdata[14:0];
                CFG_MAX_SPEED:   cfg_mdl.max_speed         <= cfg_wdata[14:0];
                CFG_ERROR_LIMIT: cfg_mdl.error_limit       <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Driver: sends the backlog in bursts with random gaps. An accepted
    // word is fed to the tracker at the very edge that takes it.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            in_word        <= '0;
            burst_left     = 1;
            gap_left       = 0;
            for (int i = 0; i < SLOTS; i++)
                arrival_us[i] = '0;
            err_lvl        = '0;
            status_mdl     = '0;
            target_is_zero = 1'b1;
            speed_mdl      = '0;
        end
        else
        begin
            if (in_valid && sample_ch.ready)
            begin
                track_plausibility(in_word);
                words_in++;
            end
            if (!in_valid || sample_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (sample_backlog.size() > 0)
                begin
                    in_word  <= sample_backlog.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        // now and then no gap or a long burst, otherwise short bursts after a gap
                        gap_left   = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(8, 1));
                        burst_left = ($urandom_range(5) == 0) ? int'($urandom_range(80, 40))
                                                              : int'($urandom_range(24, 1));
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: receiver stalls follow a pattern picked by bits 10:9 of a
    // free-running counter - always ready, coin toss, 3 of 8, mostly ready.
    // ------------------------------------------------------------------
    task automatic compare_status_word(res_t got);
        res_t want;
        if (status_due.size() == 0)
        begin
            report_mismatch("status word with no tick outstanding");
            return;
        end
        want = status_due.pop_front();
        if (got.run_ok !== want.run_ok)
            report_mismatch($sformatf("run_ok got %b want %b", got.run_ok, want.run_ok));
        if (got.steer_ok !== want.steer_ok)
            report_mismatch($sformatf("steer_ok got %b want %b", got.steer_ok, want.steer_ok));
        if (got.drive_status !== want.drive_status)
            report_mismatch($sformatf("drive_status got %0d want %0d",
                                      got.drive_status, want.drive_status));
        if (got.brake_request !== want.brake_request)
            report_mismatch($sformatf("brake_request got %0d want %0d",
                                      got.brake_request, want.brake_request));
        if (got.error_level !== want.error_level)
            report_mismatch($sformatf("error_level got %0d want %0d",
                                      got.error_level, want.error_level));
        if (got.speed !== want.speed)
            report_mismatch($sformatf("speed got %0d want %0d", got.speed, want.speed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_tick <= '0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                compare_status_word('{run_ok:        result_ch.run_ok,
                                      steer_ok:      result_ch.steer_ok,
                                      drive_status:  result_ch.drive_status,
                                      brake_request: result_ch.brake_request,
                                      error_level:   result_ch.error_level,
                                      speed:         result_ch.speed});
                results_seen++;
            end
            stall_tick <= stall_tick + 32'd1;
            case (stall_tick[10:9])
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= $urandom_range(1) == 1;
                2'd2:    out_ready <= stall_tick[2:0] < 3'd3;
                default: out_ready <= $urandom_range(7) != 0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(logic [3:0] op, int smp, logic [31:0] stamp, logic act);
        item_t w;
        w.opcode      = op;
        w.sample      = 16'(smp);
        w.time_us     = stamp;
        w.actuator_ok = act;
        sample_backlog.push_back(w);
    endtask

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Mostly plausible values for the current limits, some just outside them
    function automatic int choose_sample(logic [3:0] op);
        int lim;
        int ms;
        bit bad;
        bad = $urandom_range(99) < 8;
        ms  = int'(cfg_mdl.max_speed);
        if ($urandom_range(49) == 0)
            return span(-32768, 32767);
        case (op)
            OP_AX, OP_AY, OP_YAW, OP_STEER: begin
                if (op == OP_AX)
                    lim = int'(cfg_mdl.max_long_accel);
                else if (op == OP_AY)
                    lim = int'(cfg_mdl.max_lat_accel);
                else if (op == OP_YAW)
                    lim = int'(cfg_mdl.max_yaw_rate);
                else
                    lim = int'(STEER_LIMIT_Q);
                if (!bad)
                    return span(-lim, lim);
                if (lim < 32767 && $urandom_range(1) == 1)
                    return span(lim + 1, 32767);
                return span(-32768, -lim - 1);
            end
            OP_WHEEL0, OP_WHEEL1, OP_WHEEL2, OP_WHEEL3: begin
                if (bad && ms < 32767)
                    return span(ms + 1, 32767);
                return span(-256, ms);
            end
            OP_INV: begin
                if (bad)
                    return (ms < 32767 && $urandom_range(1) == 1) ? span(ms + 1, 32767)
                                                                  : span(-32768, -129);
                if ($urandom_range(9) < 3)
                    return span(-128, ms);
                return span(ms < 128 ? ms : 128, ms);
            end
            OP_CONE0, OP_CONE1: begin
                if (bad)
                    return ($urandom_range(1) == 1) ? 0 : span(-32768, -1);
                return span(1, 500);
            end
            OP_STATUS: begin
                if ($urandom_range(9) < 8)
                    return int'(ST_DRIVING);
                return ($urandom_range(1) == 1) ? span(0, 7) : span(-32768, 32767);
            end
            OP_TARGET:
                return ($urandom_range(3) == 0) ? 0 : span(-3000, 3000);
            default:
                return span(-32768, 32767);
        endcase
    endfunction

    // A driving session: status driving, a target, then a mix of sensor, status, target and spare words and ticks
    task automatic run_session(int count, int tick_pct);
        int          done_cnt;
        int          r;
        logic [31:0] tmo;
        logic [3:0]  op;
        done_cnt = 0;
        tmo      = 32'(cfg_mdl.sensor_timeout_us);
        queue_word(OP_STATUS, int'(ST_DRIVING), now_us, 1'b1);
        queue_word(OP_TARGET, span(200, 3000), now_us, 1'b1);
        while (done_cnt < count)
        begin
            // timestamps mostly step well inside the timeout, sometimes jump
            r = $urandom_range(99);
            if (r < 90)
                now_us = now_us + $urandom_range(tmo / 24 + 2);
            else if (r < 98)
                now_us = now_us + tmo + $urandom_range(tmo + 10);
            else
                now_us = $urandom;
            r = $urandom_range(99);
            if (r < 2)
                queue_word(($urandom_range(1) == 1) ? OP_SPARE_HI : OP_SPARE_LO,
                           span(-32768, 32767), now_us, 1'($urandom));
            else
            begin
                if (r < 2 + tick_pct)
                    op = OP_TICK;
                else if (r < 5 + tick_pct)
                    op = OP_STATUS;
                else if (r < 8 + tick_pct)
                    op = OP_TARGET;
                else
                    op = 4'($urandom_range(OP_CONE1, OP_AX));
                queue_word(op, choose_sample(op), now_us, $urandom_range(9) != 0);
                done_cnt++;
            end
        end
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic program_regs(cfg_t c);
        put_reg(CFG_CHECKS_EN,   CFG_DATA_W'(c.checks_en));
        put_reg(CFG_SENSOR_TMO,  CFG_DATA_W'(c.sensor_timeout_us));
        put_reg(CFG_MAP_TMO,     CFG_DATA_W'(c.map_timeout_us));
        put_reg(CFG_MAX_LONG,    CFG_DATA_W'(c.max_long_accel));
        put_reg(CFG_MAX_LAT,     CFG_DATA_W'(c.max_lat_accel));
        put_reg(CFG_MAX_YAW,     CFG_DATA_W'(c.max_yaw_rate));
        put_reg(CFG_MAX_SPEED,   CFG_DATA_W'(c.max_speed));
        put_reg(CFG_ERROR_LIMIT, CFG_DATA_W'(c.error_limit));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Waits until every word is taken and every tick answered, then lets the
    // pipeline run dry: sensor words give no result yet may still be in flight.
    task automatic settle();
        int waited;
        waited = 0;
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || in_valid);
        while (status_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (status_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d tick results never arrived", status_due.size()));
            status_due.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset settings
        queue_word(OP_TICK,   0,      32'd0,      1'b1);  // idle status: brakes on
        queue_word(OP_STATUS, int'(ST_DRIVING), 32'd0, 1'b1);
        queue_word(OP_TARGET, 256,    32'd0,      1'b1);
        queue_word(OP_INV,    256,    32'd1000,   1'b1);
        queue_word(OP_TICK,   0,      32'd1000,   1'b1);  // run and steer allowed
        queue_word(OP_AX,     32767,  32'd100000, 1'b1);  // late and out: counted twice
        queue_word(OP_AY,     -32768, 32'd100000, 1'b1);
        queue_word(OP_YAW,    768,    32'd100000, 1'b1);  // on the limit: fine
        queue_word(OP_YAW,    -769,   32'd100000, 1'b1);
        queue_word(OP_STEER,  5377,   32'd100010, 1'b1);
        queue_word(OP_STEER,  -5376,  32'd100020, 1'b1);
        queue_word(OP_WHEEL0, 19201,  32'd100030, 1'b1);
        queue_word(OP_WHEEL1, 19200,  32'd100040, 1'b1);
        queue_word(OP_TICK,   0,      32'd100040, 1'b1);  // error level over the limit
        queue_word(OP_CONE0,  0,      32'd100050, 1'b1);
        queue_word(OP_CONE1,  1,      32'd100060, 1'b1);
        queue_word(OP_INV,    -129,   32'd100070, 1'b1);
        queue_word(OP_INV,    -128,   32'd100080, 1'b1);
        queue_word(OP_STATUS, -5,     32'd100080, 1'b1);  // clamps to 0
        queue_word(OP_STATUS, 100,    32'd100080, 1'b1);  // clamps to 7
        queue_word(OP_STATUS, int'(ST_DRIVING), 32'd100080, 1'b1);
        queue_word(OP_TICK,   0,      32'd100080, 1'b0);  // actuator down
        queue_word(OP_SPARE_LO, 32767, 32'hFFFF_FFFF, 1'b1);
        queue_word(OP_SPARE_HI, -1,    32'hFFFF_FFFF, 1'b0);
        queue_word(OP_AX,     -3840,  32'hFFFF_FFF0, 1'b1);
        queue_word(OP_AX,     3841,   32'h0000_0010, 1'b1);  // gap across the wrap
        queue_word(OP_TARGET, 0,      32'h0000_0010, 1'b1);
        queue_word(OP_TICK,   0,      32'h0000_0010, 1'b1);  // slow, target zero: finished
        now_us = 32'h0000_0010;
        settle();

        run_session(250, 30);
        settle();

        // Widest settings, checks off
        c = '{checks_en: 1'b0, sensor_timeout_us: 20'd1000000, map_timeout_us: 22'd4000000,
              max_long_accel: 15'd32767, max_lat_accel: 15'd32767, max_yaw_rate: 15'd32767,
              max_speed: 15'd32767, error_limit: 8'd255};
        program_regs(c);
        run_session(150, 30);
        settle();

        // Tightest settings: nearly every word is an error, level saturates
        c = '{checks_en: 1'b1, sensor_timeout_us: 20'd0, map_timeout_us: 22'd0,
              max_long_accel: 15'd0, max_lat_accel: 15'd0, max_yaw_rate: 15'd0,
              max_speed: 15'd0, error_limit: 8'd0};
        program_regs(c);
        run_session(150, 10);
        settle();

        c.checks_en         = 1'b1;
        c.sensor_timeout_us = 20'($urandom_range(200000, 1000));
        c.map_timeout_us    = 22'($urandom_range(1000000, 10000));
        c.max_long_accel    = 15'($urandom);
        c.max_lat_accel     = 15'($urandom);
        c.max_yaw_rate      = 15'($urandom);
        c.max_speed         = 15'($urandom);
        c.error_limit       = 8'($urandom);
        program_regs(c);
        run_session(250, 30);
        settle();

        c.sensor_timeout_us = 20'($urandom_range(80000, 20000));
        c.map_timeout_us    = 22'($urandom_range(400000, 100000));
        c.max_long_accel    = 15'($urandom_range(8000, 512));
        c.max_lat_accel     = 15'($urandom_range(8000, 512));
        c.max_yaw_rate      = 15'($urandom_range(8000, 512));
        c.max_speed         = 15'($urandom_range(32767, 256));
        c.error_limit       = 8'd1;
        program_regs(c);
        run_session(250, 35);
        settle();

        $display("Covered %0d sample words under %0d register settings, %0d tick results checked.",
                 words_in, settings_used, results_seen);
        $display("Error level peaked at %0d; %0d ticks moved driving to finished; %0d mismatches.",
                 err_peak, finishes, mismatches);
        if (mismatches == 0)
            $display("sensor_plausibility_monitor_core test passed");
        else
            $display("sensor_plausibility_monitor_core test failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #(WATCHDOG_NS);
        $display("Watchdog expired at %0t", $time);
        $display("sensor_plausibility_monitor_core test failed");
        $finish;
    end

endmodule

[files.f]
design/spm_pkg.sv
design/spm_if.sv
design/spm_cfg_regs.sv
design/spm_eval.sv
design/sensor_plausibility_monitor_core.sv
bench/tb_top.sv
